>>> rtl/i2c_rts_pkg.sv
`default_nettype none
package i2c_rts_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ADDR,
      PH_REG,
      PH_RADDR,
      PH_RDATA,
      PH_WDATA,
      PH_RETRY
   } phase_type;

   localparam logic       KIND_REQUEST  = 1'b0;
   localparam logic       KIND_DONE     = 1'b1;
   localparam logic [4:0] NUM_DEVS      = 5'd18;
   localparam logic [3:0] RETRY_RESET   = 4'd8;
   localparam logic [1:0] STATUS_BUSY   = 2'd0;
   localparam logic [1:0] STATUS_OK     = 2'd1;
   localparam logic [1:0] STATUS_FAIL   = 2'd2;

   typedef struct packed {
      logic       kind;
      logic [4:0] dev_id;
      logic [7:0] reg_addr;
      logic       is_read;
      logic [8:0] length;
      logic       irq_mode;
      logic [7:0] tx_byte;
      logic       ack;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [7:0] cmd_byte;
      logic       cmd_start;
      logic       cmd_stop;
      logic       cmd_read;
      logic       cmd_master_ack;
      logic       cmd_error;
      logic       cmd_irq;
      logic [1:0] bus_sel;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] attempts_left;
      logic [7:0] device_address;
      logic [7:0] register_number;
      logic [1:0] active_bus;
      logic       read_flag;
      logic       irq_flag;
   } state_type;

   typedef struct packed {
      logic [1:0] bus;
      logic [7:0] addr;
   } dev_entry_type;

   function automatic dev_entry_type dev_lookup(input logic [4:0] id);
      dev_entry_type e;
      case (id)
         5'd0:    e = '{2'd0, 8'h4A};
         5'd1:    e = '{2'd0, 8'h7A};
         5'd2:    e = '{2'd0, 8'h78};
         5'd3:    e = '{2'd1, 8'h4A};
         5'd4:    e = '{2'd1, 8'h78};
         5'd5:    e = '{2'd1, 8'h2C};
         5'd6:    e = '{2'd1, 8'h2E};
         5'd7:    e = '{2'd1, 8'h40};
         5'd8:    e = '{2'd1, 8'h44};
         5'd9:    e = '{2'd2, 8'hD6};
         5'd10:   e = '{2'd2, 8'hD0};
         5'd11:   e = '{2'd2, 8'hD2};
         5'd12:   e = '{2'd2, 8'hA4};
         5'd13:   e = '{2'd2, 8'h9A};
         5'd14:   e = '{2'd2, 8'hA0};
         5'd15:   e = '{2'd1, 8'hEE};
         5'd16:   e = '{2'd0, 8'h40};
         5'd17:   e = '{2'd2, 8'h54};
         default: e = '{2'd0, 8'h00};
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

>>> rtl/i2c_rts_if.sv
`default_nettype none
interface i2c_rts_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [4:0] dev_id;
   logic [7:0] reg_addr;
   logic       is_read;
   logic [8:0] length;
   logic       irq_mode;
   logic [7:0] tx_byte;
   logic       ack;
   logic [7:0] rx_byte;

   modport source (
      output valid, kind, dev_id, reg_addr, is_read, length, irq_mode, tx_byte, ack, rx_byte,
      input  ready
   );
   modport sink (
      input  valid, kind, dev_id, reg_addr, is_read, length, irq_mode, tx_byte, ack, rx_byte,
      output ready
   );
endinterface

interface i2c_rts_rsp_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [7:0] cmd_byte;
   logic       cmd_start;
   logic       cmd_stop;
   logic       cmd_read;
   logic       cmd_master_ack;
   logic       cmd_error;
   logic       cmd_irq;
   logic [1:0] bus_sel;
   logic       rx_valid;
   logic [7:0] rx_data;
   logic [1:0] status;

   modport source (
      output valid, cmd_valid, cmd_byte, cmd_start, cmd_stop, cmd_read, cmd_master_ack,
             cmd_error, cmd_irq, bus_sel, rx_valid, rx_data, status,
      input  ready
   );
   modport sink (
      input  valid, cmd_valid, cmd_byte, cmd_start, cmd_stop, cmd_read, cmd_master_ack,
             cmd_error, cmd_irq, bus_sel, rx_valid, rx_data, status,
      output ready
   );
endinterface

interface i2c_rts_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> rtl/i2c_rts_step.sv
`default_nettype none
module i2c_rts_step
   import i2c_rts_pkg::*;
#(
   parameter int MAX_LEN = 256,
   parameter int LEN_W   = $clog2(MAX_LEN + 1)
) (
   input  var state_type        st,
   input  var logic [LEN_W-1:0] bl,
   input  var req_type          item,
   input  var logic [3:0]       retry_limit,
   output state_type            st_next,
   output logic [LEN_W-1:0]     bl_next,
   output rsp_type              res
);

   function automatic rsp_type issue(input logic [7:0] data, input logic start,
                                     input logic stop, input logic rd, input logic mack,
                                     input logic err, input logic irq, input logic [1:0] bus);
      rsp_type r;
      r                = '0;
      r.cmd_valid      = 1'b1;
      r.cmd_byte       = data;
      r.cmd_start      = start;
      r.cmd_stop       = stop;
      r.cmd_read       = rd;
      r.cmd_master_ack = mack;
      r.cmd_error      = err;
      r.cmd_irq        = irq;
      r.bus_sel        = bus;
      return r;
   endfunction

   dev_entry_type    dev;
   logic [31:0]      len_fix;
   logic [31:0]      len_sat;
   logic [LEN_W-1:0] bl_dec;
   logic             last_cur;
   logic             last_dec;
   logic [3:0]       att_dec;

   assign dev      = dev_lookup(item.dev_id);
   assign len_fix  = (item.length == '0) ? 32'd1 : {23'b0, item.length};
   assign len_sat  = (len_fix > 32'(MAX_LEN)) ? 32'(MAX_LEN) : len_fix;
   assign bl_dec   = (bl != '0) ? bl - LEN_W'(1) : bl;
   assign last_cur = (bl <= LEN_W'(1));
   assign last_dec = (bl_dec <= LEN_W'(1));
   assign att_dec  = (st.attempts_left != 4'd0) ? st.attempts_left - 4'd1 : 4'd0;

   always_comb begin
      res     = '0;
      st_next = st;
      bl_next = bl;
      if (item.kind == KIND_REQUEST) begin
         if (st.phase == PH_IDLE) begin
            if (item.dev_id >= NUM_DEVS) begin
               res.status = STATUS_FAIL;
            end else begin
               bl_next                 = len_sat[LEN_W-1:0];
               st_next.device_address  = dev.addr;
               st_next.active_bus      = dev.bus;
               st_next.register_number = item.reg_addr;
               st_next.read_flag       = item.is_read;
               st_next.irq_flag        = item.irq_mode;
               st_next.attempts_left   = (retry_limit == 4'd0) ? 4'd1 : retry_limit;
               st_next.phase           = PH_ADDR;
               res = issue(dev.addr, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, item.irq_mode, dev.bus);
            end
         end
      end else begin
         case (st.phase)
            PH_ADDR, PH_REG, PH_RADDR: begin
               if (!item.ack) begin
                  // address-side NACK: error-stop, then retry or give up
                  res = issue(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, st.irq_flag, st.active_bus);
                  st_next.attempts_left = att_dec;
                  if (att_dec == 4'd0) begin
                     res.status    = STATUS_FAIL;
                     st_next.phase = PH_IDLE;
                  end else begin
                     st_next.phase = PH_RETRY;
                  end
               end else if (st.phase == PH_ADDR) begin
                  res = issue(st.register_number, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                              st.irq_flag, st.active_bus);
                  st_next.phase = PH_REG;
               end else if (st.phase == PH_REG && st.read_flag) begin
                  res = issue(st.device_address | 8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                              st.irq_flag, st.active_bus);
                  st_next.phase = PH_RADDR;
               end else if (st.phase == PH_REG) begin
                  res = issue(item.tx_byte, 1'b0, last_cur, 1'b0, 1'b0, 1'b0,
                              st.irq_flag, st.active_bus);
                  st_next.phase = PH_WDATA;
               end else begin
                  res = issue(8'h00, 1'b0, last_cur, 1'b1, !last_cur, 1'b0,
                              st.irq_flag, st.active_bus);
                  st_next.phase = PH_RDATA;
               end
            end
            PH_RDATA: begin
               bl_next = bl_dec;
               if (bl_dec == '0) begin
                  st_next.phase = PH_IDLE;
               end else begin
                  res = issue(8'h00, 1'b0, last_dec, 1'b1, !last_dec, 1'b0,
                              st.irq_flag, st.active_bus);
               end
               res.rx_valid = 1'b1;
               res.rx_data  = item.rx_byte;
               if (bl_dec == '0) begin
                  res.status = STATUS_OK;
               end
            end
            PH_WDATA: begin
               if (!item.ack) begin
                  res = issue(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, st.irq_flag, st.active_bus);
                  res.status    = STATUS_FAIL;
                  st_next.phase = PH_IDLE;
               end else begin
                  bl_next = bl_dec;
                  if (bl_dec == '0) begin
                     res.status    = STATUS_OK;
                     st_next.phase = PH_IDLE;
                  end else begin
                     res = issue(item.tx_byte, 1'b0, last_dec, 1'b0, 1'b0, 1'b0,
                                 st.irq_flag, st.active_bus);
                  end
               end
            end
            PH_RETRY: begin
               res = issue(st.device_address, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                           st.irq_flag, st.active_bus);
               st_next.phase = PH_ADDR;
            end
            default: begin
               st_next.phase = PH_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

>>> rtl/i2c_register_transfer_sequencer.sv
// Each accepted request or completion beat waits in the input register, then passes
// the combinational sequencing logic into the result register as its result beat.
// Throughput: one beat per cycle while result beats are taken; an untaken result stalls.
// Reset (synchronous, active high) sets the phase to idle, clears both pipeline
// valids and all transfer state, and loads retry_limit with 8.
`default_nettype none
module i2c_register_transfer_sequencer
   import i2c_rts_pkg::*;
#(
   parameter int MAX_LEN = 256
) (
   input  var logic         clock,
   input  var logic         reset,
   i2c_rts_req_if.sink      req,
   i2c_rts_rsp_if.source    rsp,
   i2c_rts_csr_if.sink      csr
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);

   req_type          req_ff;
   req_type          req_in;
   logic             req_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             rsp_valid_ff;
   state_type        st_ff;
   state_type        st_in;
   logic [LEN_W-1:0] bl_ff;
   logic [LEN_W-1:0] bl_in;
   logic [3:0]       retry_ff;
   logic             out_free;
   logic             advance;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = req_valid_ff && out_free;
   assign req.ready = !req_valid_ff || out_free;
   assign csr.ready = 1'b1;

   always_comb begin
      req_in.kind     = req.kind;
      req_in.dev_id   = req.dev_id;
      req_in.reg_addr = req.reg_addr;
      req_in.is_read  = req.is_read;
      req_in.length   = req.length;
      req_in.irq_mode = req.irq_mode;
      req_in.tx_byte  = req.tx_byte;
      req_in.ack      = req.ack;
      req_in.rx_byte  = req.rx_byte;
   end

   i2c_rts_step #(
      .MAX_LEN (MAX_LEN),
      .LEN_W   (LEN_W)
   ) u_step (
      .st          (st_ff),
      .bl          (bl_ff),
      .item        (req_ff),
      .retry_limit (retry_ff),
      .st_next     (st_in),
      .bl_next     (bl_in),
      .res         (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '{phase: PH_IDLE, default: '0};
         bl_ff        <= '0;
         retry_ff     <= RETRY_RESET;
      end else begin
         if (req.valid && req.ready) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            st_ff        <= st_in;
            bl_ff        <= bl_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr.valid) begin
            retry_ff <= csr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.cmd_valid      = rsp_ff.cmd_valid;
   assign rsp.cmd_byte       = rsp_ff.cmd_byte;
   assign rsp.cmd_start      = rsp_ff.cmd_start;
   assign rsp.cmd_stop       = rsp_ff.cmd_stop;
   assign rsp.cmd_read       = rsp_ff.cmd_read;
   assign rsp.cmd_master_ack = rsp_ff.cmd_master_ack;
   assign rsp.cmd_error      = rsp_ff.cmd_error;
   assign rsp.cmd_irq        = rsp_ff.cmd_irq;
   assign rsp.bus_sel        = rsp_ff.bus_sel;
   assign rsp.rx_valid       = rsp_ff.rx_valid;
   assign rsp.rx_data        = rsp_ff.rx_data;
   assign rsp.status         = rsp_ff.status;

   // a finished or failed transfer always leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.status != STATUS_BUSY |=> st_ff.phase == PH_IDLE)
      else $error("transfer ended but phase not idle");

   // error-stop beats always carry stop and never start
   a_err_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.cmd_error |-> rsp_ff.cmd_stop && !rsp_ff.cmd_start)
      else $error("error-stop without stop");

   // success is reported without a new command
   a_ok_no_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_OK |-> !rsp_ff.cmd_valid && rsp_ff.rx_valid
         || rsp_valid_ff && rsp_ff.status == STATUS_OK && !rsp_ff.cmd_valid
            && st_ff.phase == PH_IDLE)
      else $error("success beat carries a command");

   // sequencer state only moves when a beat is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(st_ff) && $stable(bl_ff))
      else $error("state changed without a beat");

   // while addressing or waiting to retry, the attempt counter is never empty
   a_attempts: assert property (@(posedge clock) disable iff (reset)
      st_ff.phase == PH_ADDR || st_ff.phase == PH_RETRY |-> st_ff.attempts_left != 4'd0)
      else $error("attempt counter empty while addressing");

endmodule
`default_nettype wire

>>> tb/i2c_register_transfer_sequencer_tb.sv
`timescale 1ns / 100ps

module i2c_register_transfer_sequencer_tb
   import i2c_rts_pkg::*;
();

   localparam int MAX_LEN     = 256;
   localparam int REQ_W       = $bits(req_type);
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_AT     = 500;
   localparam int HOLD_LEN    = 300;
   localparam int PHASE_ITEMS = 285;

   // device table, entry 17 first
   localparam logic [18*8-1:0] ADDR_TABLE = {
      8'h54, 8'h40, 8'hEE, 8'hA0, 8'h9A, 8'hA4, 8'hD2, 8'hD0, 8'hD6,
      8'h44, 8'h40, 8'h2E, 8'h2C, 8'h78, 8'h4A, 8'h78, 8'h7A, 8'h4A
   };
   localparam logic [18*2-1:0] BUS_TABLE = {
      2'd2, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
      2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0
   };

   localparam rsp_type NO_BEAT  = '0;
   localparam rsp_type FAILED   = {26'd0, STATUS_FAIL};
   localparam rsp_type FINISHED = {26'd0, STATUS_OK};

   typedef struct packed {
      req_type item;
      logic    fixed;
      rsp_type want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset;

   i2c_rts_req_if req_chan ();
   i2c_rts_rsp_if rsp_chan ();
   i2c_rts_csr_if csr_chan ();

   i2c_register_transfer_sequencer #(.MAX_LEN(MAX_LEN)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan.sink),
      .rsp   (rsp_chan.source),
      .csr   (csr_chan.sink)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   phase_type  seq_phase = PH_IDLE;
   logic [3:0] seq_tries = '0;
   logic [8:0] seq_bytes = '0;
   logic [7:0] seq_addr  = '0;
   logic [7:0] seq_reg   = '0;
   logic [1:0] seq_bus   = '0;
   logic       seq_rd    = 1'b0;
   logic       seq_irq   = 1'b0;
   logic [3:0] retry_cfg = RETRY_RESET;
   bit         step_ignored;

   rsp_type pending_cmds [$];
   int      mismatches = 0;
   int      work_done  = 0;
   int      req_idle_pct = 19;
   int      rsp_idle_pct = 19;

   function automatic rsp_type bus_cmd(input logic [7:0] b, input logic st, input logic sp,
                                       input logic rd, input logic mack, input logic err);
      rsp_type c;
      c = '0;
      c.cmd_valid      = 1'b1;
      c.cmd_byte       = b;
      c.cmd_start      = st;
      c.cmd_stop       = sp;
      c.cmd_read       = rd;
      c.cmd_master_ack = mack;
      c.cmd_error      = err;
      c.cmd_irq        = seq_irq;
      c.bus_sel        = seq_bus;
      return c;
   endfunction

   // error-stop; retry from the address byte while attempts remain
   function automatic rsp_type addr_nack();
      rsp_type c;
      c = bus_cmd(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      if (seq_tries != 0) seq_tries = seq_tries - 1'b1;
      if (seq_tries == 0) begin
         c.status  = STATUS_FAIL;
         seq_phase = PH_IDLE;
      end else begin
         seq_phase = PH_RETRY;
      end
      return c;
   endfunction

   function automatic rsp_type read_cmd();
      logic last;
      last = (seq_bytes <= 1);
      seq_phase = PH_RDATA;
      return bus_cmd(8'h00, 1'b0, last, 1'b1, !last, 1'b0);
   endfunction

   function automatic rsp_type write_cmd(input logic [7:0] b);
      seq_phase = PH_WDATA;
      return bus_cmd(b, 1'b0, seq_bytes <= 1, 1'b0, 1'b0, 1'b0);
   endfunction

   function automatic rsp_type sequence_step(input req_type it);
      rsp_type r;
      r = '0;
      step_ignored = 1'b0;
      if (it.kind == KIND_REQUEST) begin
         if (seq_phase != PH_IDLE) begin
            step_ignored = 1'b1;
         end else if (it.dev_id >= NUM_DEVS) begin
            r.status = STATUS_FAIL;
         end else begin
            if (it.length == 0) seq_bytes = 9'd1;
            else if (it.length > MAX_LEN) seq_bytes = 9'(MAX_LEN);
            else seq_bytes = it.length;
            seq_addr  = ADDR_TABLE[it.dev_id*8 +: 8];
            seq_bus   = BUS_TABLE[it.dev_id*2 +: 2];
            seq_reg   = it.reg_addr;
            seq_rd    = it.is_read;
            seq_irq   = it.irq_mode;
            seq_tries = (retry_cfg == 0) ? 4'd1 : retry_cfg;
            r = bus_cmd(seq_addr, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            seq_phase = PH_ADDR;
         end
      end else begin
         case (seq_phase)
            PH_ADDR: begin
               if (!it.ack) begin
                  r = addr_nack();
               end else begin
                  r = bus_cmd(seq_reg, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                  seq_phase = PH_REG;
               end
            end
            PH_REG: begin
               if (!it.ack) begin
                  r = addr_nack();
               end else if (seq_rd) begin
                  r = bus_cmd(seq_addr | 8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                  seq_phase = PH_RADDR;
               end else begin
                  r = write_cmd(it.tx_byte);
               end
            end
            PH_RADDR: begin
               if (!it.ack) r = addr_nack();
               else r = read_cmd();
            end
            PH_RDATA: begin
               // ack bit means nothing on received payload
               if (seq_bytes != 0) seq_bytes = seq_bytes - 1'b1;
               if (seq_bytes == 0) begin
                  r.status  = STATUS_OK;
                  seq_phase = PH_IDLE;
               end else begin
                  r = read_cmd();
               end
               r.rx_valid = 1'b1;
               r.rx_data  = it.rx_byte;
            end
            PH_WDATA: begin
               if (!it.ack) begin
                  r = bus_cmd(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
                  r.status  = STATUS_FAIL;
                  seq_phase = PH_IDLE;
               end else begin
                  if (seq_bytes != 0) seq_bytes = seq_bytes - 1'b1;
                  if (seq_bytes == 0) begin
                     r.status  = STATUS_OK;
                     seq_phase = PH_IDLE;
                  end else begin
                     r = write_cmd(it.tx_byte);
                  end
               end
            end
            PH_RETRY: begin
               r = bus_cmd(seq_addr, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
               seq_phase = PH_ADDR;
            end
            default: begin
               step_ignored = 1'b1;
               seq_phase = PH_IDLE;
            end
         endcase
      end
      return r;
   endfunction

   function automatic req_type rq(input logic [4:0] dev, input logic [7:0] ra,
                                  input logic rd, input logic [8:0] len, input logic irq);
      req_type it;
      it = '0;
      it.kind     = KIND_REQUEST;
      it.dev_id   = dev;
      it.reg_addr = ra;
      it.is_read  = rd;
      it.length   = len;
      it.irq_mode = irq;
      return it;
   endfunction

   function automatic req_type cp(input logic ack, input logic [7:0] tx, input logic [7:0] rx);
      req_type it;
      it = '0;
      it.kind    = KIND_DONE;
      it.ack     = ack;
      it.tx_byte = tx;
      it.rx_byte = rx;
      return it;
   endfunction

   task automatic note_mismatch(input string what, input logic [8:0] got, input logic [8:0] want);
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic compare_cmd(input rsp_type got, input rsp_type want);
      if (got.cmd_valid !== want.cmd_valid)
         note_mismatch("cmd_valid", 9'(got.cmd_valid), 9'(want.cmd_valid));
      if (got.cmd_byte !== want.cmd_byte)
         note_mismatch("cmd_byte", 9'(got.cmd_byte), 9'(want.cmd_byte));
      if (got.cmd_start !== want.cmd_start)
         note_mismatch("cmd_start", 9'(got.cmd_start), 9'(want.cmd_start));
      if (got.cmd_stop !== want.cmd_stop)
         note_mismatch("cmd_stop", 9'(got.cmd_stop), 9'(want.cmd_stop));
      if (got.cmd_read !== want.cmd_read)
         note_mismatch("cmd_read", 9'(got.cmd_read), 9'(want.cmd_read));
      if (got.cmd_master_ack !== want.cmd_master_ack)
         note_mismatch("cmd_master_ack", 9'(got.cmd_master_ack), 9'(want.cmd_master_ack));
      if (got.cmd_error !== want.cmd_error)
         note_mismatch("cmd_error", 9'(got.cmd_error), 9'(want.cmd_error));
      if (got.cmd_irq !== want.cmd_irq)
         note_mismatch("cmd_irq", 9'(got.cmd_irq), 9'(want.cmd_irq));
      if (got.bus_sel !== want.bus_sel)
         note_mismatch("bus_sel", 9'(got.bus_sel), 9'(want.bus_sel));
      if (got.rx_valid !== want.rx_valid)
         note_mismatch("rx_valid", 9'(got.rx_valid), 9'(want.rx_valid));
      if (got.rx_data !== want.rx_data)
         note_mismatch("rx_data", 9'(got.rx_data), 9'(want.rx_data));
      if (got.status !== want.status)
         note_mismatch("status", 9'(got.status), 9'(want.status));
   endtask

   // one request/completion beat; expectation is queued when the beat is taken
   task automatic send_beat(input req_type it, input logic fixed, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.kind     <= it.kind;
      req_chan.dev_id   <= it.dev_id;
      req_chan.reg_addr <= it.reg_addr;
      req_chan.is_read  <= it.is_read;
      req_chan.length   <= it.length;
      req_chan.irq_mode <= it.irq_mode;
      req_chan.tx_byte  <= it.tx_byte;
      req_chan.ack      <= it.ack;
      req_chan.rx_byte  <= it.rx_byte;
      do @(posedge clock); while (!req_chan.ready);
      predicted = sequence_step(it);
      pending_cmds.push_back(fixed ? want : predicted);
      if (!step_ignored) work_done++;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_retry_limit(input logic [3:0] value);
      settle();
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      retry_cfg = value;
   endtask

   task automatic run_random(input int target);
      req_type it;
      int      stop_at;
      int      pick;
      stop_at = work_done + target;
      while (work_done < stop_at) begin
         it = REQ_W'({$urandom(), $urandom()});
         if (seq_phase == PH_IDLE) begin
            it.kind = ($urandom_range(99) < 8) ? KIND_DONE : KIND_REQUEST;
         end else begin
            it.kind = ($urandom_range(99) < 6) ? KIND_REQUEST : KIND_DONE;
         end
         if (it.kind == KIND_REQUEST && seq_phase == PH_IDLE) begin
            if ($urandom_range(99) < 90) it.dev_id = 5'($urandom_range(NUM_DEVS - 1));
            else it.dev_id = 5'($urandom_range(31, NUM_DEVS));
            // mostly short transfers, a rare full-size one
            pick = $urandom_range(199);
            if (pick == 0) it.length = 9'($urandom_range(511, 256));
            else if (pick < 14) it.length = '0;
            else if (pick < 45) it.length = 9'($urandom_range(16, 5));
            else it.length = 9'($urandom_range(4, 1));
         end else if (it.kind == KIND_DONE) begin
            it.ack = ($urandom_range(99) < 88);
         end
         send_beat(it, 1'b0, NO_BEAT);
      end
   endtask

   // result side: checks and drives ready, incl. one long hold-off
   initial begin
      rsp_type got;
      int      rsp_beats;
      int      hold_left;
      bit      hold_done;
      rsp_beats = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_chan.valid && rsp_chan.ready) begin
               got = {rsp_chan.cmd_valid, rsp_chan.cmd_byte, rsp_chan.cmd_start,
                      rsp_chan.cmd_stop, rsp_chan.cmd_read, rsp_chan.cmd_master_ack,
                      rsp_chan.cmd_error, rsp_chan.cmd_irq, rsp_chan.bus_sel,
                      rsp_chan.rx_valid, rsp_chan.rx_data, rsp_chan.status};
               if (pending_cmds.size() == 0)
                  note_mismatch("beat with nothing expected, status", 9'(got.status), 9'd0);
               else
                  compare_cmd(got, pending_cmds.pop_front());
               rsp_beats++;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_chan.ready <= 1'b0;
            end else if (!hold_done && rsp_beats >= HOLD_AT) begin
               hold_done = 1'b1;
               hold_left = HOLD_LEN - 1;
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      table_row_type directed [$];
      rsp_type       first_addr;
      first_addr = {1'b1, 8'h4A, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 2'd0, 1'b0, 8'h00,
                    STATUS_BUSY};

      reset = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.kind     = KIND_REQUEST;
      req_chan.dev_id   = '0;
      req_chan.reg_addr = '0;
      req_chan.is_read  = 1'b0;
      req_chan.length   = '0;
      req_chan.irq_mode = 1'b0;
      req_chan.tx_byte  = '0;
      req_chan.ack      = 1'b0;
      req_chan.rx_byte  = '0;
      csr_chan.valid    = 1'b0;
      csr_chan.data     = '0;

      //                item                                   fixed  want
      directed.push_back({cp(1'b1, 8'h00, 8'h00),                1'b1, NO_BEAT});  // idle done
      directed.push_back({rq(5'd31, 8'h00, 1'b0, 9'd1, 1'b0),    1'b1, FAILED});
      directed.push_back({rq(5'd18, 8'h00, 1'b0, 9'd1, 1'b0),    1'b1, FAILED});
      directed.push_back({rq(5'd0, 8'hFF, 1'b0, 9'd0, 1'b1),     1'b1, first_addr});
      directed.push_back({rq(5'd1, 8'h10, 1'b1, 9'd4, 1'b0),     1'b1, NO_BEAT});  // busy
      directed.push_back({cp(1'b1, 8'h00, 8'h00),                1'b0, NO_BEAT});
      directed.push_back({cp(1'b1, 8'hA5, 8'h00),                1'b0, NO_BEAT});
      directed.push_back({cp(1'b1, 8'h00, 8'h00),                1'b1, FINISHED});
      directed.push_back({rq(5'd17, 8'h00, 1'b1, 9'd2, 1'b0),    1'b0, NO_BEAT});
      directed.push_back({cp(1'b1, 8'hFF, 8'hFF),                1'b0, NO_BEAT});
      directed.push_back({cp(1'b1, 8'h00, 8'h00),                1'b0, NO_BEAT});
      directed.push_back({cp(1'b1, 8'h00, 8'h00),                1'b0, NO_BEAT});
      directed.push_back({cp(1'b0, 8'h00, 8'hFF),                1'b0, NO_BEAT});
      directed.push_back({cp(1'b1, 8'hFF, 8'h00),                1'b0, NO_BEAT});
      // write with length above max, address nack then payload nack
      directed.push_back({rq(5'd15, 8'h80, 1'b0, 9'd511, 1'b1),  1'b0, NO_BEAT});
      directed.push_back({cp(1'b0, 8'h00, 8'h00),                1'b0, NO_BEAT});
      directed.push_back({cp(1'b1, 8'h00, 8'h00),                1'b0, NO_BEAT});
      directed.push_back({cp(1'b1, 8'h00, 8'h00),                1'b0, NO_BEAT});
      directed.push_back({cp(1'b1, 8'h00, 8'h00),                1'b0, NO_BEAT});
      directed.push_back({cp(1'b0, 8'h5A, 8'h00),                1'b0, NO_BEAT});
      // full-size read, nack on register byte
      directed.push_back({rq(5'd9, 8'h7F, 1'b1, 9'd256, 1'b1),   1'b0, NO_BEAT});
      directed.push_back({cp(1'b1, 8'h00, 8'h00),                1'b0, NO_BEAT});
      directed.push_back({cp(1'b0, 8'h00, 8'h00),                1'b0, NO_BEAT});
      directed.push_back({cp(1'b1, 8'h00, 8'h00),                1'b0, NO_BEAT});

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_beat(directed[i].item, directed[i].fixed, directed[i].want);

      write_retry_limit(4'd1);
      run_random(PHASE_ITEMS);

      // zero means one attempt; no idling on either side here
      write_retry_limit(4'd0);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(PHASE_ITEMS);

      write_retry_limit(4'd15);
      req_idle_pct = 19;
      rsp_idle_pct = 19;
      run_random(PHASE_ITEMS);

      write_retry_limit(4'($urandom_range(14, 2)));
      run_random(PHASE_ITEMS);

      write_retry_limit(RETRY_RESET);
      run_random(PHASE_ITEMS);

      settle();
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
